>>> hdl/npr_pkg.sv
// ----------------------------------------------------------------------------
// npr_pkg - node pool scheduler shared definitions
// Widths, command and operation codes, and the structs that the sequencer
// broadcasts to the slot cells and that the cells hand along the chain.
// ----------------------------------------------------------------------------
package npr_pkg;

	// table geometry
	localparam int NODES  = 16;
	localparam int IDX_W  = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int SLOT_W = 4;
	localparam int TGT_W  = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

	// field widths
	localparam int CMD_W    = 3;
	localparam int CAP_W    = 16;
	localparam int CORES_W  = 11;
	localparam int MEM_W    = 21;
	localparam int GPUS_W   = 9;
	localparam int NCORES_W = 10;
	localparam int NMEM_W   = 20;
	localparam int NGPUS_W  = 8;
	localparam int AGE_W    = 16;
	localparam int DROP_W   = 5;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 1;

	// stream word widths
	localparam int S_DATA_W = 104;
	localparam int M_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_JOB_COST = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 1'b1;

	// register reset values
	localparam logic [CFG_W-1:0] JOB_COST_RST = 16'd20;
	localparam logic [CFG_W-1:0] TIMEOUT_RST  = 16'd2000;

	// saturation limits
	localparam logic [AGE_W-1:0] AGE_MAX = '1;

	// command codes
	localparam logic [CMD_W-1:0] CMD_BEAT    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_RESERVE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RESTORE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_TICK    = 3'd4;

	// operation broadcast to every cell
	typedef enum logic [2:0] {
		OP_NONE,
		OP_BEAT,
		OP_RESTORE,
		OP_REMOVE,
		OP_TAKE,
		OP_SCAN_RES,
		OP_SCAN_TICK
	} op_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_TAKE,
		ST_DONE
	} st_t;

	// broadcast word: operation, heartbeat values, needs and configuration
	typedef struct packed {
		op_t                 op;
		logic [CAP_W-1:0]    cap;
		logic [CORES_W-1:0]  cores;
		logic [MEM_W-1:0]    mem;
		logic [GPUS_W-1:0]   gpus;
		logic [NCORES_W-1:0] need_cores;
		logic [NMEM_W-1:0]   need_mem;
		logic [NGPUS_W-1:0]  need_gpus;
		logic [CFG_W-1:0]    job_cost;
		logic [CFG_W-1:0]    timeout;
	} bcast_t;

	// token handed from cell to cell during a scan
	typedef struct packed {
		logic              vld;
		logic              found;
		logic [CAP_W-1:0]  best_cap;
		logic [IDX_W-1:0]  best_slot;
		logic [DROP_W-1:0] dropped;
	} link_t;

endpackage

>>> hdl/npr_cell.sv
// ----------------------------------------------------------------------------
// npr_cell - one node table slot
// Holds one slot's valid mark, capacity, free resources and age. Applies
// broadcast writes when selected, and when the scan token passes it folds
// its own entry into the worst-fit choice or ages and expires itself.
// ----------------------------------------------------------------------------
module npr_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [npr_pkg::IDX_W-1:0] slot_id,
	input  logic                     sel,
	input  npr_pkg::bcast_t          bc,
	input  npr_pkg::link_t           link_i,
	output npr_pkg::link_t           link_o,
	output logic                     valid_o
);
	import npr_pkg::*;

	logic                valid_q;
	logic [AGE_W-1:0]    age_q;
	logic [CAP_W-1:0]    cap_q;
	logic [CORES_W-1:0]  cores_q;
	logic [MEM_W-1:0]    mem_q;
	logic [GPUS_W-1:0]   gpus_q;
	link_t               link_q;
	link_t               link_n;

	logic                elig;
	logic [AGE_W-1:0]    age_inc;
	logic                expire;

	logic [CAP_W:0]      cap_add;
	logic [NCORES_W:0]   cores_add;
	logic [NMEM_W:0]     mem_add;
	logic [NGPUS_W:0]    gpus_add;
	logic [CAP_W-1:0]    cap_rst;
	logic [CORES_W-1:0]  cores_rst;
	logic [MEM_W-1:0]    mem_rst;
	logic [GPUS_W-1:0]   gpus_rst;
	logic [CAP_W-1:0]    cap_sub;
	logic [CORES_W-1:0]  cores_sub;
	logic [MEM_W-1:0]    mem_sub;
	logic [GPUS_W-1:0]   gpus_sub;

	// eligibility for a reserve; an unknown (negative) resource never blocks
	assign elig = valid_q && (cap_q >= bc.job_cost)
		&& (cores_q[CORES_W-1] || (cores_q[NCORES_W-1:0] >= bc.need_cores))
		&& (mem_q[MEM_W-1] || (mem_q[NMEM_W-1:0] >= bc.need_mem))
		&& (gpus_q[GPUS_W-1] || (gpus_q[NGPUS_W-1:0] >= bc.need_gpus));

	// ageing with saturation, expiry past the timeout
	assign age_inc = (age_q == AGE_MAX) ? age_q : age_q + AGE_W'(1);
	assign expire  = valid_q && (age_inc > bc.timeout);

	// restore: saturating adds
	assign cap_add   = {1'b0, cap_q} + {1'b0, bc.job_cost};
	assign cores_add = {1'b0, cores_q[NCORES_W-1:0]} + {1'b0, bc.need_cores};
	assign mem_add   = {1'b0, mem_q[NMEM_W-1:0]} + {1'b0, bc.need_mem};
	assign gpus_add  = {1'b0, gpus_q[NGPUS_W-1:0]} + {1'b0, bc.need_gpus};
	assign cap_rst   = cap_add[CAP_W] ? '1 : cap_add[CAP_W-1:0];
	assign cores_rst = {1'b0, cores_add[NCORES_W] ? {NCORES_W{1'b1}}
		: cores_add[NCORES_W-1:0]};
	assign mem_rst   = {1'b0, mem_add[NMEM_W] ? {NMEM_W{1'b1}} : mem_add[NMEM_W-1:0]};
	assign gpus_rst  = {1'b0, gpus_add[NGPUS_W] ? {NGPUS_W{1'b1}}
		: gpus_add[NGPUS_W-1:0]};

	// reserve: subtract with a floor at zero
	assign cap_sub   = (cap_q > bc.job_cost) ? cap_q - bc.job_cost : '0;
	assign cores_sub = {1'b0, (cores_q[NCORES_W-1:0] > bc.need_cores)
		? cores_q[NCORES_W-1:0] - bc.need_cores : {NCORES_W{1'b0}}};
	assign mem_sub   = {1'b0, (mem_q[NMEM_W-1:0] > bc.need_mem)
		? mem_q[NMEM_W-1:0] - bc.need_mem : {NMEM_W{1'b0}}};
	assign gpus_sub  = {1'b0, (gpus_q[NGPUS_W-1:0] > bc.need_gpus)
		? gpus_q[NGPUS_W-1:0] - bc.need_gpus : {NGPUS_W{1'b0}}};

	// fold this slot into the passing token
	always_comb begin
		link_n = link_i;
		if (link_i.vld) begin
			if (bc.op == OP_SCAN_RES && elig && (!link_i.found || cap_q > link_i.best_cap)) begin
				link_n.found     = 1'b1;
				link_n.best_cap  = cap_q;
				link_n.best_slot = slot_id;
			end
			if (bc.op == OP_SCAN_TICK && expire) begin
				link_n.dropped = link_i.dropped + DROP_W'(1);
			end
		end
	end

	// hand the token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else begin
			link_q <= link_n;
		end
	end

	// valid mark and age
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			age_q   <= '0;
		end else begin
			unique case (bc.op)
				OP_BEAT: begin
					if (sel) begin
						valid_q <= 1'b1;
						age_q   <= '0;
					end
				end
				OP_REMOVE: begin
					if (sel) begin
						valid_q <= 1'b0;
					end
				end
				OP_SCAN_TICK: begin
					if (link_i.vld && valid_q) begin
						age_q <= age_inc;
						if (expire) begin
							valid_q <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// slot contents
	always_ff @(posedge clk) begin
		unique case (bc.op)
			OP_BEAT: begin
				if (sel) begin
					cap_q   <= bc.cap;
					cores_q <= bc.cores;
					mem_q   <= bc.mem;
					gpus_q  <= bc.gpus;
				end
			end
			OP_RESTORE: begin
				if (sel && valid_q) begin
					cap_q <= cap_rst;
					if (!cores_q[CORES_W-1]) cores_q <= cores_rst;
					if (!mem_q[MEM_W-1])     mem_q   <= mem_rst;
					if (!gpus_q[GPUS_W-1])   gpus_q  <= gpus_rst;
				end
			end
			OP_TAKE: begin
				if (sel) begin
					cap_q <= cap_sub;
					if (!cores_q[CORES_W-1]) cores_q <= cores_sub;
					if (!mem_q[MEM_W-1])     mem_q   <= mem_sub;
					if (!gpus_q[GPUS_W-1])   gpus_q  <= gpus_sub;
				end
			end
			default: begin
			end
		endcase
	end

	assign link_o  = link_q;
	assign valid_o = valid_q;

endmodule

>>> hdl/node_pool_resource_scheduler_core.sv
// ----------------------------------------------------------------------------
// node_pool_resource_scheduler_core - worst-fit node pool scheduler
// Sequencer, configuration registers and the row of slot cells.
// ----------------------------------------------------------------------------
// One command word is taken at a time. Heartbeat, restore, remove and
// undefined commands pass through the execute state and load their result
// word into the output register once it is free. Reserve and tick pass a
// token along the row of NODES slot cells, one cell per cycle; a reserve
// that finds a fitting slot then writes the deductions back to it. A
// finished result waits in the output register while the next command word
// is accepted. The table needs no clearing pass after reset.
module node_pool_resource_scheduler_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [npr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [npr_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// node_slot[3:0], beat_capacity[19:4], beat_cores[30:20], beat_memory[51:31],
	// beat_gpus[60:52], need_cores[70:61], need_memory[90:71], need_gpus[98:91]
	input  logic [npr_pkg::S_DATA_W-1:0]   s_tdata,
	// cmd[2:0]
	input  logic [npr_pkg::CMD_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// chosen_slot[3:0], dropped_count[8:4]
	output logic [npr_pkg::M_DATA_W-1:0]   m_tdata,
	// status[0]
	output logic [0:0]                     m_tuser
);
	import npr_pkg::*;

	// configuration
	logic [CFG_W-1:0]    job_cost_q;
	logic [CFG_W-1:0]    timeout_q;

	// held command word
	logic [CMD_W-1:0]    cmd_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [CAP_W-1:0]    cap_q;
	logic [CORES_W-1:0]  cores_q;
	logic [MEM_W-1:0]    mem_q;
	logic [GPUS_W-1:0]   gpus_q;
	logic [NCORES_W-1:0] ncores_q;
	logic [NMEM_W-1:0]   nmem_q;
	logic [NGPUS_W-1:0]  ngpus_q;

	// sequencer
	st_t                 state_q, state_d;
	logic [IDX_W-1:0]    pick_q, pick_d;
	logic                res_ld;
	logic                res_status_d, res_status_q;
	logic [SLOT_W-1:0]   res_chosen_d, res_chosen_q;
	logic [DROP_W-1:0]   res_drop_d, res_drop_q;
	logic                out_ld;
	op_t                 op;
	link_t               seed;

	// output register
	logic                m_tvalid_q;
	logic [SLOT_W-1:0]   m_chosen_q;
	logic [DROP_W-1:0]   m_drop_q;
	logic                m_status_q;

	// cell row
	bcast_t              bc;
	link_t               link [NODES+1];
	logic [NODES-1:0]    sel;
	logic [NODES-1:0]    valid_vec;
	logic [TGT_W-1:0]    tgt;
	logic                here;
	logic                any_sel;
	logic                accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_cost_q <= JOB_COST_RST;
			timeout_q  <= TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_JOB_COST: job_cost_q <= cfg_wdata;
				REG_TIMEOUT:  timeout_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// capture the accepted word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= s_tuser;
			slot_q   <= s_tdata[3:0];
			cap_q    <= s_tdata[19:4];
			cores_q  <= s_tdata[30:20];
			mem_q    <= s_tdata[51:31];
			gpus_q   <= s_tdata[60:52];
			ncores_q <= s_tdata[70:61];
			nmem_q   <= s_tdata[90:71];
			ngpus_q  <= s_tdata[98:91];
		end
	end

	// slot select: addressed slot, or the chosen one during write-back
	always_comb begin
		tgt = (state_q == ST_TAKE) ? TGT_W'(pick_q) : TGT_W'(slot_q);
		for (int i = 0; i < NODES; i++) begin
			sel[i] = (tgt == TGT_W'(i));
		end
	end
	assign any_sel = |sel;
	assign here    = |(sel & valid_vec);

	// next state, broadcast operation and result
	always_comb begin
		state_d      = state_q;
		pick_d       = pick_q;
		op           = OP_NONE;
		seed         = '0;
		res_ld       = 1'b0;
		res_status_d = 1'b0;
		res_chosen_d = '0;
		res_drop_d   = '0;
		out_ld       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				unique case (cmd_q)
					CMD_BEAT: begin
						op           = OP_BEAT;
						res_ld       = 1'b1;
						res_status_d = !any_sel;
						state_d      = ST_DONE;
					end
					CMD_RESTORE: begin
						op           = OP_RESTORE;
						res_ld       = 1'b1;
						res_status_d = !here;
						state_d      = ST_DONE;
					end
					CMD_REMOVE: begin
						op           = OP_REMOVE;
						res_ld       = 1'b1;
						res_status_d = !here;
						state_d      = ST_DONE;
					end
					CMD_RESERVE: begin
						op       = OP_SCAN_RES;
						seed.vld = 1'b1;
						state_d  = ST_SCAN;
					end
					CMD_TICK: begin
						op       = OP_SCAN_TICK;
						seed.vld = 1'b1;
						state_d  = ST_SCAN;
					end
					default: begin
						res_ld  = 1'b1;
						state_d = ST_DONE;
					end
				endcase
			end
			ST_SCAN: begin
				op = (cmd_q == CMD_TICK) ? OP_SCAN_TICK : OP_SCAN_RES;
				if (link[NODES].vld) begin
					if (cmd_q == CMD_TICK) begin
						res_ld     = 1'b1;
						res_drop_d = link[NODES].dropped;
						state_d    = ST_DONE;
					end else if (link[NODES].found) begin
						pick_d  = link[NODES].best_slot;
						state_d = ST_TAKE;
					end else begin
						res_ld       = 1'b1;
						res_status_d = 1'b1;
						state_d      = ST_DONE;
					end
				end
			end
			ST_TAKE: begin
				op           = OP_TAKE;
				res_ld       = 1'b1;
				res_chosen_d = SLOT_W'(pick_q);
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_ld  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// pick and pending result
	always_ff @(posedge clk) begin
		pick_q <= pick_d;
		if (res_ld) begin
			res_status_q <= res_status_d;
			res_chosen_q <= res_chosen_d;
			res_drop_q   <= res_drop_d;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_ld) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			m_status_q <= res_status_q;
			m_chosen_q <= res_chosen_q;
			m_drop_q   <= res_drop_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_DATA_W-SLOT_W-DROP_W){1'b0}}, m_drop_q, m_chosen_q};
	assign m_tuser  = m_status_q;

	// broadcast word
	always_comb begin
		bc            = '0;
		bc.op         = op;
		bc.cap        = cap_q;
		bc.cores      = cores_q;
		bc.mem        = mem_q;
		bc.gpus       = gpus_q;
		bc.need_cores = ncores_q;
		bc.need_mem   = nmem_q;
		bc.need_gpus  = ngpus_q;
		bc.job_cost   = job_cost_q;
		bc.timeout    = timeout_q;
	end

	// row of slot cells
	assign link[0] = seed;

	for (genvar g = 0; g < NODES; g++) begin : g_cell
		npr_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.slot_id (IDX_W'(g)),
			.sel     (sel[g]),
			.bc      (bc),
			.link_i  (link[g]),
			.link_o  (link[g+1]),
			.valid_o (valid_vec[g])
		);
	end

`ifndef SYNTH
	// write-back only targets a slot that is still valid
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAKE) |-> here)
		else $error("write-back to a slot that is not valid");

	// the token leaves the row only while a scan is running
	a_token_scan: assert property (@(posedge clk) disable iff (!arst_n)
		link[NODES].vld |-> (state_q == ST_SCAN))
		else $error("scan token outside a scan");

	// an accepted word starts execution next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC))
		else $error("accepted word not executed");

	// a finished result reaches the output register when it is free
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && (!m_tvalid || m_tready)) |=>
			(m_tvalid && state_q == ST_IDLE))
		else $error("result not delivered to output register");
`endif

endmodule

>>> bench/npr_result_checker.sv
// ----------------------------------------------------------------------------
// npr_result_checker - result checker for the node pool scheduler
// Watches the command and result streams and the register port. Keeps its
// own copy of the node table and the two registers, works out the result
// word of every accepted command and compares it field by field with the
// words the block hands out, in order.
// ----------------------------------------------------------------------------
module npr_result_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [npr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [npr_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	// node_slot, beat_capacity, beat_cores, beat_memory, beat_gpus,
	// need_cores, need_memory, need_gpus
	input  logic [npr_pkg::S_DATA_W-1:0]   s_tdata,
	// cmd
	input  logic [npr_pkg::CMD_W-1:0]      s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	// chosen_slot, dropped_count
	input  logic [npr_pkg::M_DATA_W-1:0]   m_tdata,
	// status
	input  logic [0:0]                     m_tuser,
	output int                             mismatch_count,
	output int                             awaited_words,
	output int                             results_checked,
	output int                             nodes_placed,
	output int                             nodes_expired
);
	timeunit 1ns;
	timeprecision 1ps;
	import npr_pkg::*;

	// saturation limits of the stored amounts
	localparam int CAP_TOP   = 2 ** CAP_W - 1;
	localparam int CORES_TOP = 2 ** (CORES_W - 1) - 1;
	localparam int MEM_TOP   = 2 ** (MEM_W - 1) - 1;
	localparam int GPUS_TOP  = 2 ** (GPUS_W - 1) - 1;

	// command word, last field in the highest bits
	typedef struct packed {
		logic [NGPUS_W-1:0]  need_gpus;
		logic [NMEM_W-1:0]   need_mem;
		logic [NCORES_W-1:0] need_cores;
		logic [GPUS_W-1:0]   gpus;
		logic [MEM_W-1:0]    mem;
		logic [CORES_W-1:0]  cores;
		logic [CAP_W-1:0]    cap;
		logic [SLOT_W-1:0]   slot;
	} request_t;

	localparam int REQ_W = $bits(request_t);

	typedef struct packed {
		logic              status;
		logic [SLOT_W-1:0] chosen;
		logic [DROP_W-1:0] dropped;
	} outcome_t;

	// node table and register copies
	logic                      node_live  [NODES];
	logic [CAP_W-1:0]          node_cap   [NODES];
	logic signed [CORES_W-1:0] node_cores [NODES];
	logic signed [MEM_W-1:0]   node_mem   [NODES];
	logic signed [GPUS_W-1:0]  node_gpus  [NODES];
	logic [AGE_W-1:0]          node_age   [NODES];
	logic [CFG_W-1:0]          cost_reg;
	logic [CFG_W-1:0]          timeout_reg;

	outcome_t outcome_q [$];
	outcome_t want;
	outcome_t seen;
	int       fails;
	int       checked;
	int       placed;
	int       expired;

	function automatic int floor_sub(int a, int b);
		return (a > b) ? a - b : 0;
	endfunction

	function automatic int sat_add(int a, int b, int hi);
		return (a + b > hi) ? hi : a + b;
	endfunction

	// an unknown amount never blocks a job
	function automatic bit fits(int have, int need);
		return (have < 0) || (have >= need);
	endfunction

	// apply one command to the table and return the result word it gives
	function automatic outcome_t apply_command(logic [CMD_W-1:0] op, request_t rq);
		outcome_t res;
		int       sl;
		int       best;
		int       pick;
		bit       hit;
		res  = '0;
		sl   = rq.slot;
		best = -1;
		pick = 0;
		hit  = 1'b0;
		case (op)
			CMD_BEAT: begin
				if (sl < NODES) begin
					node_live[sl]  = 1'b1;
					node_cap[sl]   = rq.cap;
					node_cores[sl] = $signed(rq.cores);
					node_mem[sl]   = $signed(rq.mem);
					node_gpus[sl]  = $signed(rq.gpus);
					node_age[sl]   = '0;
				end else begin
					res.status = 1'b1;
				end
			end
			CMD_RESERVE: begin
				// largest capacity wins, the lowest slot on a tie
				for (int i = 0; i < NODES; i++) begin
					if (node_live[i] && node_cap[i] >= cost_reg &&
					    fits(node_cores[i], rq.need_cores) &&
					    fits(node_mem[i], rq.need_mem) &&
					    fits(node_gpus[i], rq.need_gpus) &&
					    int'(node_cap[i]) > best) begin
						best = node_cap[i];
						pick = i;
						hit  = 1'b1;
					end
				end
				if (hit) begin
					node_cap[pick] = CAP_W'(floor_sub(node_cap[pick], cost_reg));
					if (node_cores[pick] >= 0)
						node_cores[pick] =
							CORES_W'(floor_sub(node_cores[pick], rq.need_cores));
					if (node_mem[pick] >= 0)
						node_mem[pick] = MEM_W'(floor_sub(node_mem[pick], rq.need_mem));
					if (node_gpus[pick] >= 0)
						node_gpus[pick] =
							GPUS_W'(floor_sub(node_gpus[pick], rq.need_gpus));
					res.chosen = pick[SLOT_W-1:0];
					placed++;
				end else begin
					res.status = 1'b1;
				end
			end
			CMD_RESTORE: begin
				if (sl < NODES && node_live[sl]) begin
					node_cap[sl] = CAP_W'(sat_add(node_cap[sl], cost_reg, CAP_TOP));
					if (node_cores[sl] >= 0)
						node_cores[sl] =
							CORES_W'(sat_add(node_cores[sl], rq.need_cores, CORES_TOP));
					if (node_mem[sl] >= 0)
						node_mem[sl] =
							MEM_W'(sat_add(node_mem[sl], rq.need_mem, MEM_TOP));
					if (node_gpus[sl] >= 0)
						node_gpus[sl] =
							GPUS_W'(sat_add(node_gpus[sl], rq.need_gpus, GPUS_TOP));
				end else begin
					res.status = 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (sl < NODES && node_live[sl])
					node_live[sl] = 1'b0;
				else
					res.status = 1'b1;
			end
			CMD_TICK: begin
				// age live nodes, saturating, and drop the stale ones
				for (int i = 0; i < NODES; i++) begin
					if (node_live[i]) begin
						if (node_age[i] != AGE_MAX)
							node_age[i] = node_age[i] + 1'b1;
						if (node_age[i] > timeout_reg) begin
							node_live[i] = 1'b0;
							res.dropped  = res.dropped + 1'b1;
							expired++;
						end
					end
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic void report(string field, int expected, int actual);
		$display("%0t ns: %s mismatch, expected %0d, actual %0d",
		         $time, field, expected, actual);
		fails++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++) begin
				node_live[i]  = 1'b0;
				node_cap[i]   = '0;
				node_cores[i] = '0;
				node_mem[i]   = '0;
				node_gpus[i]  = '0;
				node_age[i]   = '0;
			end
			cost_reg    = JOB_COST_RST;
			timeout_reg = TIMEOUT_RST;
			outcome_q.delete();
			fails   = 0;
			checked = 0;
			placed  = 0;
			expired = 0;
		end else begin
			// track register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_JOB_COST: cost_reg    = cfg_wdata;
					REG_TIMEOUT:  timeout_reg = cfg_wdata;
					default: begin
					end
				endcase
			end
			// check the result word against the oldest expectation
			if (m_tvalid && m_tready) begin
				seen = {m_tuser[0], m_tdata[SLOT_W-1:0], m_tdata[SLOT_W +: DROP_W]};
				if (outcome_q.size() == 0) begin
					$display("%0t ns: unexpected result word, status %0d slot %0d drop %0d",
					         $time, seen.status, seen.chosen, seen.dropped);
					fails++;
				end else begin
					want = outcome_q.pop_front();
					checked++;
					if (seen.status != want.status)
						report("status", want.status, seen.status);
					if (seen.chosen != want.chosen)
						report("chosen_slot", want.chosen, seen.chosen);
					if (seen.dropped != want.dropped)
						report("dropped_count", want.dropped, seen.dropped);
				end
			end
			// predict the result of an accepted command word
			if (s_tvalid && s_tready)
				outcome_q = {outcome_q,
				             apply_command(s_tuser, request_t'(s_tdata[REQ_W-1:0]))};
		end
		mismatch_count  <= fails;
		awaited_words   <= outcome_q.size();
		results_checked <= checked;
		nodes_placed    <= placed;
		nodes_expired   <= expired;
	end

endmodule

>>> bench/tb_node_pool_resource_scheduler_core.sv
// ----------------------------------------------------------------------------
// tb_node_pool_resource_scheduler_core - node pool scheduler testbench
// Drives a directed run over empty slots, unknown and odd negative amounts,
// ties, saturation and spare command codes, then random command streams
// under eight register settings with varying sender gaps and result stalls.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_node_pool_resource_scheduler_core;
	timeunit 1ns;
	timeprecision 1ps;
	import npr_pkg::*;

	localparam int CLK_PERIOD      = 12;
	localparam int RESET_CYCLES    = 7;
	localparam int PHASES          = 8;
	localparam int WORDS_PER_PHASE = 200;
	// allow a reserve to finish after the last result
	localparam int SETTLE_CYCLES   = 24;
	// longest quiet stretch: a reserve plus a long run of result stalls
	localparam int WATCHDOG_LIMIT  = 4000;

	// command codes the block does not define
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata   = '0;
	logic [CMD_W-1:0]      s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;
	logic [0:0]            m_tuser;

	int mismatch_count;
	int awaited_words;
	int results_checked;
	int nodes_placed;
	int nodes_expired;
	int idle_pct     = 0;
	int stall_pct    = 0;
	int cur_cost     = 20;
	int words_sent   = 0;
	int quiet_cycles = 0;
	int cost_plan    [PHASES];
	int timeout_plan [PHASES];

	node_pool_resource_scheduler_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	npr_result_checker result_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.mismatch_count  (mismatch_count),
		.awaited_words   (awaited_words),
		.results_checked (results_checked),
		.nodes_placed    (nodes_placed),
		.nodes_expired   (nodes_expired)
	);

	// clock
	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	// stall the result side at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// count cycles in which no word moves on either side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("%0t ns: no word moved for %0d cycles, %0d results outstanding",
		         $time, WATCHDOG_LIMIT, awaited_words);
		$display("node_pool_resource_scheduler_core verification failed");
		$finish;
	end

	// offer one command word, idling first at random, and hold until taken
	task automatic send_word(input logic [CMD_W-1:0] op, input logic [S_DATA_W-1:0] word);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= word;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
	endtask

	// pack the fields, first field lowest, and send
	task automatic issue(
		input int op,
		input int slot,
		input int cap,
		input int cores,
		input int mem,
		input int gpus,
		input int need_cores,
		input int need_mem,
		input int need_gpus
	);
		logic [S_DATA_W-1:0] word;
		word = S_DATA_W'({need_gpus[NGPUS_W-1:0], need_mem[NMEM_W-1:0],
		                  need_cores[NCORES_W-1:0], gpus[GPUS_W-1:0], mem[MEM_W-1:0],
		                  cores[CORES_W-1:0], cap[CAP_W-1:0], slot[SLOT_W-1:0]});
		send_word(op[CMD_W-1:0], word);
	endtask

	// drop valid and wait until every result is back and the block is quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited_words != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value[CFG_W-1:0];
		@(posedge clk);
	endtask

	task automatic configure(input int cost, input int timeout_val);
		settle();
		write_reg(REG_JOB_COST, cost);
		write_reg(REG_TIMEOUT, timeout_val);
		cfg_we   <= 1'b0;
		cur_cost = cost;
	endtask

	// one random command: mostly heartbeats and reserves with modest needs,
	// so that nodes fill up, get used, restored and age out
	task automatic random_command();
		int roll;
		int cap;
		int op;
		int cores;
		int mem;
		int gpus;
		int nc;
		int nm;
		int ng;
		roll = $urandom_range(99);
		if (roll < 30)
			op = CMD_BEAT;
		else if (roll < 60)
			op = CMD_RESERVE;
		else if (roll < 74)
			op = CMD_RESTORE;
		else if (roll < 82)
			op = CMD_REMOVE;
		else if (roll < 95)
			op = CMD_TICK;
		else
			op = $urandom_range(CMD_SPARE_LO, CMD_SPARE_HI);
		// capacity: full range, just above the job cost, the top, or low
		case ($urandom_range(3))
			0: cap = $urandom_range(2 ** CAP_W - 1);
			1: cap = cur_cost + $urandom_range(100);
			2: cap = 2 ** CAP_W - 1;
			default: cap = $urandom_range(255);
		endcase
		if (cap > 2 ** CAP_W - 1)
			cap = 2 ** CAP_W - 1;
		// free amounts: mostly known, sometimes unknown or another negative
		roll = $urandom_range(19);
		cores = (roll < 2) ? -1 : (roll < 3) ? $urandom_range(1024, 2047)
		                                     : $urandom_range(1023);
		roll = $urandom_range(19);
		mem = (roll < 2) ? -1 : (roll < 3) ? $urandom_range(2 ** 20, 2 ** 21 - 1)
		                                   : $urandom_range(2 ** 20 - 1);
		roll = $urandom_range(19);
		gpus = (roll < 2) ? -1 : (roll < 3) ? $urandom_range(256, 511)
		                                    : $urandom_range(255);
		// needs: mostly small, now and then anything
		if ($urandom_range(3) == 0) begin
			nc = $urandom_range(1023);
			nm = $urandom_range(2 ** 20 - 1);
			ng = $urandom_range(255);
		end else begin
			nc = $urandom_range(7);
			nm = $urandom_range(4095);
			ng = $urandom_range(3);
		end
		issue(op, $urandom_range(15), cap, cores, mem, gpus, nc, nm, ng);
	endtask

	initial begin
		cost_plan    = '{20, 0, 65535, 1, 300, 40, 65535, 0};
		timeout_plan = '{2000, 0, 65535, 1, 3, 8, 2, 0};
		cost_plan[PHASES-1]    = $urandom_range(65535);
		timeout_plan[PHASES-1] = $urandom_range(1, 40);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: nothing to reserve, restore or remove
		issue(CMD_RESERVE, 0, 0, 0, 0, 0, 0, 0, 0);
		issue(CMD_TICK,    0, 0, 0, 0, 0, 0, 0, 0);
		issue(CMD_REMOVE,  3, 0, 0, 0, 0, 0, 0, 0);
		issue(CMD_RESTORE, 3, 0, 0, 0, 0, 0, 0, 0);
		// fill: all unknown, all at the top, all zero, odd negatives
		issue(CMD_BEAT,  0, 65535, -1, -1, -1, 0, 0, 0);
		issue(CMD_BEAT, 15, 65535, 1023, 1048575, 255, 0, 0, 0);
		issue(CMD_BEAT,  7, 0, 0, 0, 0, 0, 0, 0);
		issue(CMD_BEAT,  4, 20, -1024, -1048576, -256, 0, 0, 0);
		// tie at the top capacity goes to the lowest slot
		issue(CMD_RESERVE, 0, 0, 0, 0, 0, 1023, 1048575, 255);
		issue(CMD_RESERVE, 0, 0, 0, 0, 0, 0, 0, 0);
		issue(CMD_RESERVE, 0, 0, 0, 0, 0, 1023, 0, 0);
		// restore with the largest amounts saturates, unknowns stay put
		issue(CMD_RESTORE, 15, 0, 0, 0, 0, 1023, 1048575, 255);
		issue(CMD_RESTORE,  0, 0, 0, 0, 0, 1023, 1048575, 255);
		issue(CMD_RESERVE,  0, 0, 0, 0, 0, 512, 600000, 255);
		issue(CMD_REMOVE,   0, 0, 0, 0, 0, 0, 0, 0);
		issue(CMD_REMOVE,   0, 0, 0, 0, 0, 0, 0, 0);
		issue(CMD_RESTORE,  0, 0, 0, 0, 0, 1, 1, 1);
		// spare command codes with every field at its top
		for (int code = CMD_SPARE_LO; code <= CMD_SPARE_HI; code++)
			issue(code, 15, 65535, 1023, 1048575, 255, 1023, 1048575, 255);
		issue(CMD_TICK,    0, 0, 0, 0, 0, 0, 0, 0);
		issue(CMD_BEAT,    9, 65535, -1, -1, -1, 0, 0, 0);
		issue(CMD_RESERVE, 0, 0, 0, 0, 0, 1023, 1048575, 255);
		issue(CMD_TICK,    0, 0, 0, 0, 0, 0, 0, 0);

		// random streams under each register setting and idling profile
		for (int p = 0; p < PHASES; p++) begin
			configure(cost_plan[p], timeout_plan[p]);
			case (p % 4)
				0: begin
					idle_pct  = 0;
					stall_pct <= 0;
				end
				1: begin
					idle_pct  = 54;
					stall_pct <= 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct <= 54;
				end
				default: begin
					idle_pct  = 6;
					stall_pct <= 6;
				end
			endcase
			repeat (WORDS_PER_PHASE) random_command();
		end

		settle();
		$display("Sent %0d command words over %0d register settings; %0d results checked.",
		         words_sent, PHASES + 1, results_checked);
		$display("Reserves placed %0d jobs and ticks expired %0d nodes.",
		         nodes_placed, nodes_expired);
		if (mismatch_count == 0)
			$display("node_pool_resource_scheduler_core verification clean");
		else
			$display("node_pool_resource_scheduler_core verification failed");
		$finish;
	end

endmodule

>>> sim.f
hdl/npr_pkg.sv
hdl/npr_cell.sv
hdl/node_pool_resource_scheduler_core.sv
bench/npr_result_checker.sv
bench/tb_node_pool_resource_scheduler_core.sv
